// ===== sv/schedule_hole_classifier_assert.svh =====
// Assertion macros for the schedule hole classifier checker.
`ifndef SCHEDULE_HOLE_CLASSIFIER_ASSERT_SVH
`define SCHEDULE_HOLE_CLASSIFIER_ASSERT_SVH

// Clocked assertion that is switched off while reset is applied.
`define SHC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SHC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/shc_pkg.sv =====
// ----------------------------------------------------------------------------
// Schedule hole classifier package
// Sizes, codes and the stored operation record.
// ----------------------------------------------------------------------------
`default_nettype none
package shc_pkg;
    localparam int MAX_OPS      = 256;
    localparam int MAX_MACHINES = 16;
    localparam int OP_W         = $clog2(MAX_OPS);
    localparam int CNT_W        = OP_W + 1;
    localparam int JOB_W        = 8;
    localparam int MACH_W       = $clog2(MAX_MACHINES) > 0 ? $clog2(MAX_MACHINES) : 1;
    localparam int TIME_W       = 24;
    localparam int CLASS_W      = 2;

    localparam logic [CLASS_W-1:0] CLASS_NON_DELAY   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_SEMI_ACTIVE = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_ACTIVE      = 2'd2;

    typedef struct packed {
        logic [JOB_W-1:0]  job;
        logic [MACH_W-1:0] mach;
        logic [TIME_W-1:0] fin;
        logic [TIME_W-1:0] run;
    } t_op;
endpackage
`default_nettype wire

// ===== sv/shc_if.sv =====
// ----------------------------------------------------------------------------
// Schedule hole classifier channels
// Valid/ready interfaces for operation beats and class beats.
// ----------------------------------------------------------------------------
`default_nettype none
interface shc_op_if;
    logic                         valid;
    logic                         ready;
    logic [shc_pkg::JOB_W-1:0]    job_number;
    logic [shc_pkg::MACH_W-1:0]   machine_number;
    logic [shc_pkg::TIME_W-1:0]   finish_time;
    logic [shc_pkg::TIME_W-1:0]   run_length;
    logic                         last_op;
    modport source (output valid, job_number, machine_number, finish_time, run_length,
                    last_op, input ready);
    modport sink (input valid, job_number, machine_number, finish_time, run_length,
                  last_op, output ready);
endinterface

interface shc_class_if;
    logic                         valid;
    logic                         ready;
    logic [shc_pkg::CLASS_W-1:0]  schedule_class;
    modport source (output valid, schedule_class, input ready);
    modport sink (input valid, schedule_class, output ready);
endinterface
`default_nettype wire

// ===== sv/schedule_hole_classifier.sv =====
// ----------------------------------------------------------------------------
// Schedule hole classifier
// Stores a job-shop operation list and classifies the schedule it describes.
// ----------------------------------------------------------------------------
// Usage: operations arrive on i_op, one beat per operation in sequence order,
// and are written into a simple dual-port operation memory at one beat per cycle.
// Beats beyond the memory depth are dropped. The beat with last_op set is
// stored too and starts the classification, during which i_op is not ready.
// The classifier walks the list through its one memory read port: for
// each operation it scans all earlier entries for its job, then walks back
// along its machine, and for each earlier scheduled operation on that
// machine scans the entries below it to find the hole edges. The run time
// is thus data dependent. The class leaves on o_class as one beat and the
// block returns to loading a new list. A stalled o_class holds its beat;
// the block waits at the end of a classification until the earlier beat
// is taken. Synchronous active-low reset empties the list and clears the
// output; memory contents stay.
// ----------------------------------------------------------------------------
`default_nettype none
module schedule_hole_classifier (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    shc_op_if.sink      i_op,
    shc_class_if.source o_class
);
    typedef enum logic [3:0] {
        ST_LOAD, ST_C_RD, ST_C_DATA, ST_J_RD, ST_J_DATA, ST_P_RD, ST_P_DATA,
        ST_H_RD, ST_H_DATA, ST_EVAL, ST_FINISH
    } t_state;

    localparam int CW = shc_pkg::CNT_W;
    localparam int TW = shc_pkg::TIME_W;

    // Operation memory, read data registered.
    shc_pkg::t_op r_mem [shc_pkg::MAX_OPS];
    shc_pkg::t_op r_rd;
    logic [shc_pkg::OP_W-1:0] n_rd_addr;
    logic                     wr_en;
    shc_pkg::t_op             wr_op;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;   // stored operations
    logic [CW-1:0] r_c, n_c;           // current operation index
    logic [CW-1:0] r_i, n_i;           // entries left in an inner scan
    logic [CW-1:0] r_p, n_p;           // entries left in the machine walk

    // Current operation.
    logic [shc_pkg::JOB_W-1:0]  r_job, n_job;
    logic [shc_pkg::MACH_W-1:0] r_mach, n_mach;
    logic signed [TW:0]         r_start_c, n_start_c;
    logic [TW-1:0]              r_run_c, n_run_c;
    // Job predecessors: any, and scheduled.
    logic [TW-1:0] r_a, n_a;
    logic          r_a_found, n_a_found;
    logic [TW-1:0] r_jr, n_jr;
    logic          r_jr_found, n_jr_found;
    // Machine predecessor p and what lies below it.
    logic signed [TW:0] r_sb, n_sb;
    logic [TW-1:0]      r_b, n_b;
    logic               r_b_found, n_b_found;
    logic [TW-1:0]      r_q_fin, n_q_fin;
    logic               r_q_found, n_q_found;
    logic               r_hole, n_hole;

    logic r_semi, n_semi;
    logic r_act, n_act;
    logic r_out_valid, n_out_valid;
    logic [shc_pkg::CLASS_W-1:0] r_class, n_class;

    logic signed [TW:0]   rd_fin_s;
    logic signed [TW+1:0] sb_w, jr_w, sc_w;
    logic [TW-1:0]        edge_t;
    logic signed [TW+2:0] slack;
    logic                 hit, fits_hole;
    logic                 in_acc;

    assign in_acc           = i_op.valid && i_op.ready;
    assign i_op.ready       = (r_state == ST_LOAD);
    assign o_class.valid    = r_out_valid;
    assign o_class.schedule_class = r_class;

    assign wr_en = in_acc && (r_count < CW'(shc_pkg::MAX_OPS));
    assign wr_op = '{job: i_op.job_number, mach: i_op.machine_number,
                     fin: i_op.finish_time, run: i_op.run_length};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[shc_pkg::OP_W-1:0]] <= wr_op;
        end
        r_rd <= r_mem[n_rd_addr];
    end

    // Evaluation of one hole found before operation p.
    assign rd_fin_s = $signed({1'b0, r_rd.fin});
    assign sb_w  = {r_sb[TW], r_sb};
    assign jr_w  = $signed({2'b00, r_jr});
    assign sc_w  = {r_start_c[TW], r_start_c};
    assign edge_t = (r_a > r_b) ? r_a : r_b;
    assign slack = {{2{r_sb[TW]}}, r_sb} - $signed({3'b000, edge_t})
                   - $signed({3'b000, r_run_c});

    always_comb begin
        if ((r_jr == '0) && (r_sb != '0)) begin
            hit = r_q_found && ($signed({1'b0, r_q_fin}) != r_sb);
        end else if ((r_sb != '0) && (sb_w < sc_w) && (sb_w > jr_w)) begin
            hit = r_hole;
        end else begin
            hit = 1'b0;
        end
        fits_hole = hit && r_hole;
    end

    always_comb begin
        n_state = r_state;   n_count = r_count;   n_c = r_c;   n_i = r_i;   n_p = r_p;
        n_job = r_job;       n_mach = r_mach;     n_start_c = r_start_c;
        n_run_c = r_run_c;   n_a = r_a;           n_a_found = r_a_found;
        n_jr = r_jr;         n_jr_found = r_jr_found;
        n_sb = r_sb;         n_b = r_b;           n_b_found = r_b_found;
        n_q_fin = r_q_fin;   n_q_found = r_q_found; n_hole = r_hole;
        n_semi = r_semi;     n_act = r_act;       n_class = r_class;
        n_out_valid = r_out_valid && !o_class.ready;
        n_rd_addr = r_c[shc_pkg::OP_W-1:0];

        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (wr_en) begin
                        n_count = r_count + CW'(1);
                    end
                    if (i_op.last_op) begin
                        n_c = CW'(1);
                        n_semi = 1'b0;
                        n_act = 1'b0;
                        n_state = ST_C_RD;
                    end
                end
            end
            ST_C_RD: begin
                if (r_c >= r_count) begin
                    n_state = ST_FINISH;
                end else begin
                    n_rd_addr = r_c[shc_pkg::OP_W-1:0];
                    n_state = ST_C_DATA;
                end
            end
            ST_C_DATA: begin
                n_job = r_rd.job;
                n_mach = r_rd.mach;
                n_run_c = r_rd.run;
                n_start_c = $signed({1'b0, r_rd.fin}) - $signed({1'b0, r_rd.run});
                n_a = '0;  n_a_found = 1'b0;
                n_jr = '0; n_jr_found = 1'b0;
                n_i = r_c;
                n_state = ST_J_RD;
            end
            ST_J_RD: begin
                if (r_i == '0) begin
                    n_p = r_c;
                    n_state = ST_P_RD;
                end else begin
                    n_rd_addr = shc_pkg::OP_W'(r_i - CW'(1));
                    n_i = r_i - CW'(1);
                    n_state = ST_J_DATA;
                end
            end
            ST_J_DATA: begin
                if (r_rd.job == r_job) begin
                    if (!r_a_found) begin
                        n_a = r_rd.fin;
                        n_a_found = 1'b1;
                    end
                    if (!r_jr_found && (r_rd.fin != '0)) begin
                        n_jr = r_rd.fin;
                        n_jr_found = 1'b1;
                    end
                end
                n_state = ST_J_RD;
            end
            ST_P_RD: begin
                if (r_p == '0) begin
                    n_c = r_c + CW'(1);
                    n_state = ST_C_RD;
                end else begin
                    n_rd_addr = shc_pkg::OP_W'(r_p - CW'(1));
                    n_p = r_p - CW'(1);
                    n_state = ST_P_DATA;
                end
            end
            ST_P_DATA: begin
                if ((r_rd.mach == r_mach) && (r_rd.fin != '0)) begin
                    n_sb = $signed({1'b0, r_rd.fin}) - $signed({1'b0, r_rd.run});
                    n_b = '0;      n_b_found = 1'b0;
                    n_q_fin = '0;  n_q_found = 1'b0;
                    n_hole = 1'b1;
                    n_i = r_p;
                    n_state = ST_H_RD;
                end else begin
                    n_state = ST_P_RD;
                end
            end
            ST_H_RD: begin
                if (r_i == '0) begin
                    n_state = ST_EVAL;
                end else begin
                    n_rd_addr = shc_pkg::OP_W'(r_i - CW'(1));
                    n_i = r_i - CW'(1);
                    n_state = ST_H_DATA;
                end
            end
            ST_H_DATA: begin
                if (r_rd.mach == r_mach) begin
                    if (!r_b_found) begin
                        n_b = r_rd.fin;
                        n_b_found = 1'b1;
                    end
                    if (r_rd.fin != '0) begin
                        if (!r_q_found) begin
                            n_q_fin = r_rd.fin;
                            n_q_found = 1'b1;
                        end
                        if (rd_fin_s == r_sb) begin
                            n_hole = 1'b0;
                        end
                    end
                end
                n_state = ST_H_RD;
            end
            ST_EVAL: begin
                if (fits_hole && slack[TW+2]) begin
                    n_act = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    if (fits_hole) begin
                        n_semi = 1'b1;
                    end
                    n_state = ST_P_RD;
                end
            end
            ST_FINISH: begin
                // Wait here until the previous class beat has left; the class
                // register only changes once that beat is gone.
                if (!r_out_valid || o_class.ready) begin
                    if (r_act) begin
                        n_class = shc_pkg::CLASS_ACTIVE;
                    end else if (r_semi) begin
                        n_class = shc_pkg::CLASS_SEMI_ACTIVE;
                    end else begin
                        n_class = shc_pkg::CLASS_NON_DELAY;
                    end
                    n_out_valid = 1'b1;
                    n_count = '0;
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_c <= '0;
            r_i <= '0;
            r_p <= '0;
            r_semi <= 1'b0;
            r_act <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_c <= n_c;
            r_i <= n_i;
            r_p <= n_p;
            r_semi <= n_semi;
            r_act <= n_act;
            r_out_valid <= n_out_valid;
        end
        r_job <= n_job;         r_mach <= n_mach;       r_start_c <= n_start_c;
        r_run_c <= n_run_c;     r_a <= n_a;             r_a_found <= n_a_found;
        r_jr <= n_jr;           r_jr_found <= n_jr_found;
        r_sb <= n_sb;           r_b <= n_b;             r_b_found <= n_b_found;
        r_q_fin <= n_q_fin;     r_q_found <= n_q_found; r_hole <= n_hole;
        r_class <= n_class;
    end
endmodule
`default_nettype wire

// ===== sv/shc_checker.sv =====
// ----------------------------------------------------------------------------
// Schedule hole classifier port checker
// Checks the top-level channels over time and binds to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "schedule_hole_classifier_assert.svh"
module shc_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_in_last,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [shc_pkg::CLASS_W-1:0]  i_out_class
);
    `SHC_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_class)), "class beat changed while stalled")
    `SHC_ASSERT(a_class_code, i_clk, i_rst_n, i_out_valid |-> (i_out_class == shc_pkg::CLASS_NON_DELAY || i_out_class == shc_pkg::CLASS_SEMI_ACTIVE || i_out_class == shc_pkg::CLASS_ACTIVE), "class code out of range")
    `SHC_ASSERT(a_busy_after_last, i_clk, i_rst_n, (i_in_valid && i_in_ready && i_in_last) |=> !i_in_ready, "input ready right after the last operation")
    `SHC_ASSERT_ALWAYS(a_reset_out, i_clk, !i_rst_n |=> !i_out_valid, "class beat shown after reset")
endmodule

bind schedule_hole_classifier shc_checker u_shc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_op.valid),
    .i_in_ready  (i_op.ready),
    .i_in_last   (i_op.last_op),
    .i_out_valid (o_class.valid),
    .i_out_ready (o_class.ready),
    .i_out_class (o_class.schedule_class)
);
`default_nettype wire
